// ----- rtl/nts_pkg.sv -----
// shared types and constants of the negative triple sampler
package nts_pkg;

  localparam int POS_W = 16;
  localparam int ENT_W = 12;
  localparam int REL_W = 10;
  localparam int CNT_W = 13;
  localparam int SIG_W = 18;
  localparam int WORD_W = REL_W + ENT_W;
  localparam int TRIPLES = 65536;
  localparam int ENTITIES = 4096;

  localparam logic [1:0] CMD_LOAD_HEAD = 2'd0;
  localparam logic [1:0] CMD_LOAD_TAIL = 2'd1;
  localparam logic [1:0] CMD_SAMPLE_TAIL = 2'd2;
  localparam logic [1:0] CMD_SAMPLE_HEAD = 2'd3;

  localparam logic CFG_ENTITY_COUNT = 1'b0;
  localparam logic CFG_RANDOM_SEED = 1'b1;

  localparam logic [31:0] LCG_MUL_LO = 32'hDEEC_E66D;
  localparam logic [2:0] LCG_MUL_HI = 3'd5;
  localparam logic [63:0] LCG_ADD = 64'd11;

  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NOP = 5'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 5'd1;
  localparam logic [OP_W-1:0] OP_LOAD = 5'd2;
  localparam logic [OP_W-1:0] OP_START = 5'd3;
  localparam logic [OP_W-1:0] OP_RANGE = 5'd4;
  localparam logic [OP_W-1:0] OP_PROBE = 5'd5;
  localparam logic [OP_W-1:0] OP_LEFT_UPD = 5'd6;
  localparam logic [OP_W-1:0] OP_LEFT_END = 5'd7;
  localparam logic [OP_W-1:0] OP_RIGHT_UPD = 5'd8;
  localparam logic [OP_W-1:0] OP_RIGHT_END = 5'd9;
  localparam logic [OP_W-1:0] OP_READ_RR = 5'd10;
  localparam logic [OP_W-1:0] OP_CAP_RR = 5'd11;
  localparam logic [OP_W-1:0] OP_CHECK = 5'd12;
  localparam logic [OP_W-1:0] OP_MUL_LO = 5'd13;
  localparam logic [OP_W-1:0] OP_MUL_HI = 5'd14;
  localparam logic [OP_W-1:0] OP_MUL_SUM = 5'd15;
  localparam logic [OP_W-1:0] OP_DIV = 5'd16;
  localparam logic [OP_W-1:0] OP_MAP = 5'd17;
  localparam logic [OP_W-1:0] OP_PART_UPD = 5'd18;
  localparam logic [OP_W-1:0] OP_PART_END = 5'd19;
  localparam logic [OP_W-1:0] OP_OUT = 5'd20;

  typedef struct packed {
    logic [1:0]       command;
    logic [POS_W-1:0] position;
    logic [ENT_W-1:0] entity;
    logic [REL_W-1:0] relation;
    logic [ENT_W-1:0] partner_entity;
  } in_item_t;

  typedef struct packed {
    logic [ENT_W-1:0] sampled_entity;
    logic             fault;
  } out_item_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic range_bad;
    logic lo_lt_hi;
    logic check_bad;
    logic div_last;
    logic map_direct;
    logic out_busy;
  } dp_status_t;

endpackage

// ----- rtl/nts_ctrl.sv -----
// sequencer of the negative triple sampler
module nts_ctrl import nts_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_command,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam logic [3:0] S_CLR = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RANGE = 4'd2;
  localparam logic [3:0] S_LEFT = 4'd3;
  localparam logic [3:0] S_LEFT_W = 4'd4;
  localparam logic [3:0] S_RIGHT = 4'd5;
  localparam logic [3:0] S_RIGHT_W = 4'd6;
  localparam logic [3:0] S_RDRR = 4'd7;
  localparam logic [3:0] S_CAPRR = 4'd8;
  localparam logic [3:0] S_CHECK = 4'd9;
  localparam logic [3:0] S_MUL0 = 4'd10;
  localparam logic [3:0] S_MUL1 = 4'd11;
  localparam logic [3:0] S_MUL2 = 4'd12;
  localparam logic [3:0] S_DIV = 4'd13;
  localparam logic [3:0] S_PART = 4'd14;
  localparam logic [3:0] S_PART_W = 4'd15;

  logic [3:0] state_r, state_nxt;
  logic       done_r, done_nxt;
  logic       map_r, map_nxt;

  assign in_ready = (state_r == S_IDLE) && !done_r && !map_r;

  always_comb begin
    state_nxt = state_r;
    done_nxt = done_r;
    map_nxt = map_r;
    cmd.op = OP_NOP;
    if (done_r) begin
      if (!status.out_busy) begin
        cmd.op = OP_OUT;
        done_nxt = 1'b0;
      end
    end else if (map_r) begin
      cmd.op = OP_MAP;
      map_nxt = 1'b0;
      if (status.map_direct) begin
        done_nxt = 1'b1;
      end else begin
        state_nxt = S_PART;
      end
    end else begin
      case (state_r)
        S_CLR: begin
          cmd.op = OP_CLEAR;
          if (status.clr_last) state_nxt = S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            if (in_command inside {CMD_LOAD_HEAD, CMD_LOAD_TAIL}) begin
              cmd.op = OP_LOAD;
            end else begin
              cmd.op = OP_START;
              state_nxt = S_RANGE;
            end
          end
        end
        S_RANGE: begin
          cmd.op = OP_RANGE;
          if (status.range_bad) begin
            state_nxt = S_IDLE;
            done_nxt = 1'b1;
          end else begin
            state_nxt = S_LEFT;
          end
        end
        S_LEFT: begin
          if (status.lo_lt_hi) begin
            cmd.op = OP_PROBE;
            state_nxt = S_LEFT_W;
          end else begin
            cmd.op = OP_LEFT_END;
            state_nxt = S_RIGHT;
          end
        end
        S_LEFT_W: begin
          cmd.op = OP_LEFT_UPD;
          state_nxt = S_LEFT;
        end
        S_RIGHT: begin
          if (status.lo_lt_hi) begin
            cmd.op = OP_PROBE;
            state_nxt = S_RIGHT_W;
          end else begin
            cmd.op = OP_RIGHT_END;
            state_nxt = S_RDRR;
          end
        end
        S_RIGHT_W: begin
          cmd.op = OP_RIGHT_UPD;
          state_nxt = S_RIGHT;
        end
        S_RDRR: begin
          cmd.op = OP_READ_RR;
          state_nxt = S_CAPRR;
        end
        S_CAPRR: begin
          cmd.op = OP_CAP_RR;
          state_nxt = S_CHECK;
        end
        S_CHECK: begin
          cmd.op = OP_CHECK;
          if (status.check_bad) begin
            state_nxt = S_IDLE;
            done_nxt = 1'b1;
          end else begin
            state_nxt = S_MUL0;
          end
        end
        S_MUL0: begin
          cmd.op = OP_MUL_LO;
          state_nxt = S_MUL1;
        end
        S_MUL1: begin
          cmd.op = OP_MUL_HI;
          state_nxt = S_MUL2;
        end
        S_MUL2: begin
          cmd.op = OP_MUL_SUM;
          state_nxt = S_DIV;
        end
        S_DIV: begin
          cmd.op = OP_DIV;
          if (status.div_last) begin
            state_nxt = S_IDLE;
            map_nxt = 1'b1;
          end
        end
        S_PART: begin
          if (status.lo_lt_hi) begin
            cmd.op = OP_PROBE;
            state_nxt = S_PART_W;
          end else begin
            cmd.op = OP_PART_END;
            state_nxt = S_IDLE;
            done_nxt = 1'b1;
          end
        end
        S_PART_W: begin
          cmd.op = OP_PART_UPD;
          state_nxt = S_PART;
        end
        default: state_nxt = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      done_r <= 1'b0;
      map_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r <= done_nxt;
      map_r <= map_nxt;
    end
  end

endmodule

// ----- rtl/nts_dpath.sv -----
// tables, range memories, searches, generator and modulo of the sampler
module nts_dpath import nts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  input  in_item_t    in_data,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [63:0] cfg_wdata,
  input  logic        out_ready,
  output logic        out_valid,
  output out_item_t   out_data,
  output dp_status_t  status
);

  logic [WORD_W-1:0] head_tab [TRIPLES];
  logic [WORD_W-1:0] tail_tab [TRIPLES];
  logic [POS_W-1:0]  hfirst_mem [ENTITIES];
  logic [POS_W-1:0]  hlast_mem [ENTITIES];
  logic [POS_W-1:0]  tfirst_mem [ENTITIES];
  logic [POS_W-1:0]  tlast_mem [ENTITIES];

  logic [WORD_W-1:0] hrd_r, trd_r, word;
  logic [POS_W-1:0]  hf_r, hl_r, tf_r, tl_r, first_d, last_d;
  logic [ENT_W-1:0]  clr_idx_r;
  logic [ENT_W-1:0]  prev_key_r [2];
  logic [CNT_W-1:0]  ent_cnt_r;
  logic [63:0]       gen_r, div_r, p0_r;
  logic [31:0]       p1_r;
  logic [5:0]        div_cnt_r;
  logic [ENT_W:0]    rem_r, rem_sh, rem_sub;
  logic              which_r, fault_r, out_valid_r;
  logic [REL_W-1:0]  rel_r, rel_ll_r, rel_rr_r;
  logic [ENT_W-1:0]  p_ll_r, p_rr_r, res_r;
  logic signed [SIG_W-1:0] lo_r, hi_r, mid_r, ll_r, rr_r, mid, cnt_s, n_s;
  logic signed [SIG_W-1:0] k_s, rr_bound, part_val, res_direct;
  logic [ENT_W-1:0]  cnt_u;
  logic [POS_W-1:0]  tab_addr;
  logic [ENT_W-1:0]  rng_addr;
  logic              rng_we, first_we, ld_which;
  logic [ENT_W-1:0]  rng_waddr;
  logic [POS_W-1:0]  rng_wdata;
  out_item_t         out_r;

  assign word = which_r ? trd_r : hrd_r;
  assign first_d = which_r ? tf_r : hf_r;
  assign last_d = which_r ? tl_r : hl_r;
  assign mid = lo_r + ((hi_r - lo_r) >>> 1);
  assign n_s = (ent_cnt_r > CNT_W'(ENTITIES)) ? SIG_W'(ENTITIES) : SIG_W'(ent_cnt_r);
  assign cnt_s = n_s - (rr_r - ll_r + SIG_W'(1));
  assign cnt_u = cnt_s[ENT_W-1:0];
  assign k_s = SIG_W'(rem_r);
  assign rr_bound = SIG_W'(p_rr_r) - rr_r + ll_r - SIG_W'(1);
  assign part_val = SIG_W'(word[ENT_W-1:0]) - mid_r + ll_r - SIG_W'(1);
  assign res_direct = k_s + rr_r - ll_r + SIG_W'(1);
  assign rem_sh = {rem_r[ENT_W-1:0], div_r[63]};
  assign rem_sub = (rem_sh >= {1'b0, cnt_u}) ? rem_sh - {1'b0, cnt_u} : rem_sh;

  always_comb begin
    status.clr_last = (clr_idx_r == {ENT_W{1'b1}});
    status.range_bad = first_d > last_d;
    status.lo_lt_hi = (lo_r + SIG_W'(1)) < hi_r;
    status.check_bad = (ll_r > rr_r) || (rel_ll_r != rel_r) || (rel_rr_r != rel_r)
                       || (cnt_s <= SIG_W'(0));
    status.div_last = (div_cnt_r == 6'd63);
    status.map_direct = (k_s < SIG_W'(p_ll_r)) || (k_s > rr_bound);
    status.out_busy = out_valid_r;
  end

  // one table read address, shared by all probes
  always_comb begin
    case (cmd.op)
      OP_RIGHT_END: tab_addr = ll_r[POS_W-1:0];
      OP_READ_RR:   tab_addr = rr_r[POS_W-1:0];
      default:      tab_addr = mid[POS_W-1:0];
    endcase
  end

  assign rng_addr = in_data.entity;
  assign ld_which = in_data.command[0];
  assign rng_we = (cmd.op == OP_CLEAR) || (cmd.op == OP_LOAD);
  assign first_we = (cmd.op == OP_CLEAR) || (in_data.entity != prev_key_r[ld_which]);
  assign rng_waddr = (cmd.op == OP_CLEAR) ? clr_idx_r : in_data.entity;
  assign rng_wdata = (cmd.op == OP_CLEAR) ? '0 : in_data.position;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD && !ld_which)
      head_tab[in_data.position] <= {in_data.relation, in_data.partner_entity};
    if (cmd.op == OP_LOAD && ld_which)
      tail_tab[in_data.position] <= {in_data.relation, in_data.partner_entity};
    hrd_r <= head_tab[tab_addr];
    trd_r <= tail_tab[tab_addr];
  end

  // range memories are written on clear and load; range bounds are captured once, when the sample transaction is taken
  always_ff @(posedge clk) begin
    if (rng_we && first_we && (cmd.op == OP_CLEAR || !ld_which))
      hfirst_mem[rng_waddr] <= rng_wdata;
    if (rng_we && (cmd.op == OP_CLEAR || !ld_which))
      hlast_mem[rng_waddr] <= rng_wdata;
    if (rng_we && first_we && (cmd.op == OP_CLEAR || ld_which))
      tfirst_mem[rng_waddr] <= rng_wdata;
    if (rng_we && (cmd.op == OP_CLEAR || ld_which))
      tlast_mem[rng_waddr] <= rng_wdata;
    if (cmd.op == OP_START) begin
      hf_r <= hfirst_mem[rng_addr];
      hl_r <= hlast_mem[rng_addr];
      tf_r <= tfirst_mem[rng_addr];
      tl_r <= tlast_mem[rng_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
      prev_key_r[0] <= '0;
      prev_key_r[1] <= '0;
      ent_cnt_r <= CNT_W'(ENTITIES);
      gen_r <= 64'd1;
      out_valid_r <= 1'b0;
      div_cnt_r <= '0;
    end else begin
      if (cmd.op == OP_CLEAR) clr_idx_r <= clr_idx_r + ENT_W'(1);
      if (cmd.op == OP_LOAD) prev_key_r[ld_which] <= in_data.entity;
      if (cfg_we && cfg_addr == CFG_ENTITY_COUNT) ent_cnt_r <= cfg_wdata[CNT_W-1:0];
      if (cfg_we && cfg_addr == CFG_RANDOM_SEED) gen_r <= cfg_wdata;
      if (cmd.op == OP_MUL_SUM)
        gen_r <= p0_r + {p1_r + 32'(gen_r[31:0] * LCG_MUL_HI), 32'd0} + LCG_ADD;
      if (cmd.op == OP_MUL_SUM) div_cnt_r <= '0;
      if (cmd.op == OP_DIV) div_cnt_r <= div_cnt_r + 6'd1;
      if (cmd.op == OP_OUT) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_START: begin
        which_r <= in_data.command == CMD_SAMPLE_HEAD;
        rel_r <= in_data.relation;
        fault_r <= 1'b0;
      end
      OP_RANGE: begin
        fault_r <= status.range_bad;
        lo_r <= SIG_W'(first_d) - SIG_W'(1);
        hi_r <= SIG_W'(last_d);
      end
      OP_PROBE: mid_r <= mid;
      OP_LEFT_UPD: begin
        if (word[WORD_W-1:ENT_W] >= rel_r) hi_r <= mid_r;
        else lo_r <= mid_r;
      end
      OP_LEFT_END: begin
        ll_r <= hi_r;
        lo_r <= SIG_W'(first_d);
        hi_r <= SIG_W'(last_d) + SIG_W'(1);
      end
      OP_RIGHT_UPD: begin
        if (word[WORD_W-1:ENT_W] <= rel_r) lo_r <= mid_r;
        else hi_r <= mid_r;
      end
      OP_RIGHT_END: rr_r <= lo_r;
      OP_READ_RR: begin
        rel_ll_r <= word[WORD_W-1:ENT_W];
        p_ll_r <= word[ENT_W-1:0];
      end
      OP_CAP_RR: begin
        rel_rr_r <= word[WORD_W-1:ENT_W];
        p_rr_r <= word[ENT_W-1:0];
      end
      OP_CHECK: fault_r <= status.check_bad;
      OP_MUL_LO: p0_r <= gen_r[31:0] * LCG_MUL_LO;
      OP_MUL_HI: p1_r <= 32'(gen_r[63:32] * LCG_MUL_LO);
      OP_MUL_SUM: begin
        div_r <= p0_r + {p1_r + 32'(gen_r[31:0] * LCG_MUL_HI), 32'd0} + LCG_ADD;
        rem_r <= '0;
      end
      OP_DIV: begin
        rem_r <= rem_sub;
        div_r <= {div_r[62:0], 1'b0};
      end
      OP_MAP: begin
        if (k_s < SIG_W'(p_ll_r)) res_r <= rem_r[ENT_W-1:0];
        else res_r <= res_direct[ENT_W-1:0];
        lo_r <= ll_r;
        hi_r <= rr_r + SIG_W'(1);
      end
      OP_PART_UPD: begin
        if (part_val < k_s) lo_r <= mid_r;
        else hi_r <= mid_r;
      end
      OP_PART_END: begin
        res_r <= ENT_W'(k_s + lo_r - ll_r + SIG_W'(1));
      end
      OP_OUT: begin
        out_r.sampled_entity <= fault_r ? '0 : res_r;
        out_r.fault <= fault_r;
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

endmodule

// ----- rtl/negative_triple_sampler_top.sv -----
// top level of the negative triple sampler
// a sample ends with a fault result when the entity's range is empty; when it draws it
// runs two range binary searches (at most 16 probes each), the generator multiply in
// low, high and sum steps, a bit-serial modulo of the 64-bit generator value and a
// partner search of at most 12 probes
// one sample is in flight at a time; the output register lets loads continue
// reset is synchronous and active low; after it a clearing pass over all 4096 entities
// zeroes the range memories and holds in_ready low; the tables are not cleared
module negative_triple_sampler_top import nts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [63:0] cfg_wdata
);

  // command and status between the sequencer and the datapath
  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer: clearing pass, searches, generator, modulo, result hand-off
  nts_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_data.command),
    .in_ready   (in_ready),
    .status     (status),
    .cmd        (cmd)
  );

  // datapath: tables, range memories, search bounds, lcg and result register
  nts_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .status    (status)
  );

endmodule

// ----- rtl/nts_checker.sv -----
// port-level assertions of the negative triple sampler
module nts_checker import nts_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // a result transaction held back keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a fault result carries no entity
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.fault |-> out_data.sampled_entity == '0)
    else $error("fault result with nonzero entity");

  // clearing pass follows reset, so no input transaction right after it
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input taken during clearing pass");

  // the first cycle after reset shows no result
  a_no_out_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result right after reset");

endmodule

bind negative_triple_sampler_top nts_checker u_nts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
